[hdl/atdlp_pkg.sv]
// Shared types, character codes and helpers for the temperature/depth line parser.
package atdlp_pkg;

  localparam int MAX_LINE_DEF = 20;

  localparam int IN_TDATA_W  = 8;
  localparam int TEMP_W      = 18;
  localparam int DEPTH_W     = 15;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int ACC_W       = 17;
  localparam int MC_W        = 3;
  localparam int CSE_W       = 3;

  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [MC_W-1:0]  MC_MAX    = 3'd7;
  localparam logic [MC_W-1:0]  MC_T_OPEN = 3'd1;
  localparam logic [MC_W-1:0]  MC_T_DOT  = 3'd2;
  localparam logic [MC_W-1:0]  MC_D_OPEN = 3'd3;
  localparam logic [MC_W-1:0]  MC_D_DOT  = 3'd4;
  localparam logic [CSE_W-1:0] CSE_MAX   = 3'd4;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic signed [DEPTH_W-1:0] depth_centi;
    logic                      temperature_updated;
    logic                      depth_updated;
  } res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic [ACC_W-1:0] mul10_add(input logic [ACC_W-1:0] acc,
                                                 input logic [7:0] b);
    logic [ACC_W-1:0] d;
    d = {{(ACC_W-4){1'b0}}, b[3:0]};
    return (acc << 3) + (acc << 1) + d;
  endfunction

endpackage

[hdl/atdlp_in_stage.sv]
// Input register holding one received byte until the parser takes it.
module atdlp_in_stage
  import atdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  step_en,
  output logic                  byte_valid,
  output logic [7:0]            byte_q
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_tready  = !valid_r || step_en;
  assign accept     = in_tvalid && in_tready;
  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata[7:0];
    end
  end

endmodule

[hdl/atdlp_core.sv]
// Line and field parser state with its update for each byte.
module atdlp_core
  import atdlp_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_q,
  input  logic       step_en,
  output logic       emit,
  output res_t       res
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

  logic                      in_line_r, in_line_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [MC_W-1:0]           mc_r, mc_nxt;
  logic [CSE_W-1:0]          cse_r, cse_nxt;
  logic                      minus_r, minus_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic                      bad_r, bad_nxt;
  logic signed [TEMP_W-1:0]  held_t_r, held_t_nxt;
  logic signed [DEPTH_W-1:0] held_d_r, held_d_nxt;
  logic signed [TEMP_W-1:0]  pend_t_r, pend_t_nxt;
  logic signed [DEPTH_W-1:0] pend_d_r, pend_d_nxt;
  logic                      tr_r, tr_nxt;
  logic                      dr_r, dr_nxt;

  logic                      dig;
  logic                      len_ok;
  logic [MC_W-1:0]           mc_inc;
  logic [ACC_W-1:0]          acc_mac;
  logic                      field_ok;
  logic signed [TEMP_W-1:0]  frac_val;

  assign dig     = is_digit(byte_q);
  assign len_ok  = len_r < LEN_MAX;
  assign mc_inc  = (mc_r == MC_MAX) ? mc_r : mc_r + MC_W'(1);
  assign acc_mac = mul10_add(acc_r, byte_q);
  assign emit    = byte_valid && in_line_r && len_ok && (byte_q == CHAR_NL);

  always_comb begin
    field_ok = ((cse_r == CSE_W'(1)) && !minus_r) || (cse_r == CSE_W'(2)) ||
               ((cse_r == CSE_W'(3)) && !minus_r && (mc_inc == MC_T_DOT));
    frac_val = minus_r ? -$signed({1'b0, acc_mac}) : $signed({1'b0, acc_mac});
  end

  always_comb begin
    in_line_nxt = in_line_r;
    len_nxt     = len_r;
    mc_nxt      = mc_r;
    cse_nxt     = cse_r;
    minus_nxt   = minus_r;
    acc_nxt     = acc_r;
    bad_nxt     = bad_r;
    held_t_nxt  = held_t_r;
    held_d_nxt  = held_d_r;
    pend_t_nxt  = pend_t_r;
    pend_d_nxt  = pend_d_r;
    tr_nxt      = tr_r;
    dr_nxt      = dr_r;
    if (step_en) begin
      priority if (!in_line_r) begin
        if (byte_q == CHAR_T) begin
          in_line_nxt = 1'b1;
          len_nxt     = LEN_W'(1);
          mc_nxt      = '0;
          cse_nxt     = '0;
          minus_nxt   = 1'b0;
          acc_nxt     = '0;
          bad_nxt     = 1'b0;
          tr_nxt      = 1'b0;
          dr_nxt      = 1'b0;
        end
      end else if (!len_ok) begin
        in_line_nxt = 1'b0;
      end else if (byte_q == CHAR_NL) begin
        len_nxt     = len_r + LEN_W'(1);
        in_line_nxt = 1'b0;
        if (tr_r) begin
          held_t_nxt = pend_t_r;
        end
        if (dr_r) begin
          held_d_nxt = pend_d_r;
        end
      end else if ((byte_q == CHAR_EQ) || (byte_q == CHAR_DOT)) begin
        len_nxt = len_r + LEN_W'(1);
        mc_nxt  = mc_inc;
        if ((mc_inc == MC_T_OPEN) || (mc_inc == MC_D_OPEN)) begin
          cse_nxt   = '0;
          minus_nxt = 1'b0;
          acc_nxt   = '0;
          bad_nxt   = 1'b0;
        end else if ((mc_inc == MC_T_DOT) || (mc_inc == MC_D_DOT)) begin
          if (!field_ok) begin
            bad_nxt = 1'b1;
          end
          cse_nxt = '0;
        end
      end else begin
        len_nxt = len_r + LEN_W'(1);
        if ((mc_r == MC_T_OPEN) || (mc_r == MC_D_OPEN)) begin
          priority if ((cse_r == '0) && (byte_q == CHAR_MINUS)) begin
            minus_nxt = 1'b1;
          end else if (dig) begin
            if (cse_r < CSE_W'(3)) begin
              acc_nxt = acc_mac;
            end
          end else begin
            bad_nxt = 1'b1;
          end
          if (cse_r < CSE_MAX) begin
            cse_nxt = cse_r + CSE_W'(1);
          end
        end else if ((mc_r == MC_T_DOT) || (mc_r == MC_D_DOT)) begin
          if (cse_r < CSE_W'(2)) begin
            acc_nxt = acc_mac;
            bad_nxt = bad_r || !dig;
            cse_nxt = cse_r + CSE_W'(1);
            if ((cse_r == CSE_W'(1)) && !bad_r && dig) begin
              if (mc_r == MC_T_DOT) begin
                pend_t_nxt = frac_val;
                tr_nxt     = 1'b1;
              end else begin
                pend_d_nxt = frac_val[DEPTH_W-1:0];
                dr_nxt     = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r <= 1'b0;
      len_r     <= '0;
      mc_r      <= '0;
      cse_r     <= '0;
      minus_r   <= 1'b0;
      acc_r     <= '0;
      bad_r     <= 1'b0;
      held_t_r  <= '0;
      held_d_r  <= '0;
      pend_t_r  <= '0;
      pend_d_r  <= '0;
      tr_r      <= 1'b0;
      dr_r      <= 1'b0;
    end else begin
      in_line_r <= in_line_nxt;
      len_r     <= len_nxt;
      mc_r      <= mc_nxt;
      cse_r     <= cse_nxt;
      minus_r   <= minus_nxt;
      acc_r     <= acc_nxt;
      bad_r     <= bad_nxt;
      held_t_r  <= held_t_nxt;
      held_d_r  <= held_d_nxt;
      pend_t_r  <= pend_t_nxt;
      pend_d_r  <= pend_d_nxt;
      tr_r      <= tr_nxt;
      dr_r      <= dr_nxt;
    end
  end

  always_comb begin
    res.temperature_centi   = held_t_nxt;
    res.depth_centi         = held_d_nxt;
    res.temperature_updated = tr_r;
    res.depth_updated       = dr_r;
  end

endmodule

[hdl/atdlp_out_stage.sv]
// Result register that holds one parsed line result until it is taken.
module atdlp_out_stage
  import atdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   res,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-TEMP_W-DEPTH_W){1'b0}},
                       res_r.depth_centi, res_r.temperature_centi};
  assign out_tuser  = {res_r.depth_updated, res_r.temperature_updated};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

[hdl/ascii_temp_depth_line_parser.sv]
// Top level of the ASCII temperature/depth line parser.
// A newline item is taken into the input register, and its result is then loaded into the output register.
// Throughput: 1 item per cycle; only a newline item waits, while the output holds a result.
// Other bytes keep flowing while a result waits to be taken.
// Reset: synchronous, active low; clears line state, held values and both valid flags.
module ascii_temp_depth_line_parser
  import atdlp_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [17:0] temperature_centi, [32:18] depth_centi
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] temperature_updated, [1] depth_updated
);

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       step_en;
  logic       emit;
  logic       free;
  res_t       res;

  assign step_en = byte_valid && (!emit || free);

  atdlp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .step_en    (step_en),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  atdlp_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .step_en    (step_en),
    .emit       (emit),
    .res        (res)
  );

  atdlp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && emit),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[hdl/atdlp_checker.sv]
// Port-level checks for the line parser, bound to the top level.
module atdlp_checker
  import atdlp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_new_from_nl: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2) && ($past(in_tdata, 2) == CHAR_NL))
    else $error("result without a newline item two cycles before");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

endmodule

bind ascii_temp_depth_line_parser atdlp_checker u_atdlp_checker (.*);

[verif/tb.sv]
// Testbench for the ASCII temperature/depth line parser: random framed lines, stalls, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atdlp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_ITEMS = 1250;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

  class depth_line_scoreboard;
    bit                 in_line = 1'b0;
    int unsigned        line_len = 0;
    logic [MC_W-1:0]    marks = '0;
    logic [4:0]         since_mark = '0;
    bit                 minus = 1'b0;
    logic [ACC_W-1:0]   acc = '0;
    bit                 bad = 1'b0;
    logic signed [TEMP_W-1:0]  temp_held = '0;
    logic signed [TEMP_W-1:0]  temp_pend = '0;
    logic signed [DEPTH_W-1:0] depth_held = '0;
    logic signed [DEPTH_W-1:0] depth_pend = '0;
    bit                 temp_rdy = 1'b0;
    bit                 depth_rdy = 1'b0;
    res_t               readings_q[$];
    int unsigned        errors = 0;

    function void note_byte(logic [7:0] b);
      res_t r;
      bit   is_dec;
      is_dec = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      if (!in_line) begin
        if (b == CHAR_T) begin
          in_line = 1'b1;
          line_len = 1;
          marks = '0;
          since_mark = '0;
          minus = 1'b0;
          acc = '0;
          bad = 1'b0;
          temp_rdy = 1'b0;
          depth_rdy = 1'b0;
        end
        return;
      end
      // drop the whole line once it runs past the length limit
      if (line_len >= MAX_LINE_DEF) begin
        in_line = 1'b0;
        return;
      end
      line_len++;
      if (b == CHAR_NL) begin
        if (temp_rdy) temp_held = temp_pend;
        if (depth_rdy) depth_held = depth_pend;
        r.temperature_centi = temp_held;
        r.depth_centi = depth_held;
        r.temperature_updated = temp_rdy;
        r.depth_updated = depth_rdy;
        readings_q.push_back(r);
        in_line = 1'b0;
      end else if (b == CHAR_EQ || b == CHAR_DOT) begin
        if (marks != MC_MAX) marks++;
        if (marks == MC_T_OPEN || marks == MC_D_OPEN) begin
          since_mark = '0;
          minus = 1'b0;
          acc = '0;
          bad = 1'b0;
        end else if (marks == MC_T_DOT || marks == MC_D_DOT) begin
          if (!((since_mark == 1 && !minus) || since_mark == 2 ||
                (since_mark == 3 && !minus && marks == MC_T_DOT)))
            bad = 1'b1;
          since_mark = '0;
        end
      end else if (marks == MC_T_OPEN || marks == MC_D_OPEN) begin
        if (since_mark == 0 && b == CHAR_MINUS) minus = 1'b1;
        else if (is_dec) begin
          if (since_mark < 3) acc = ACC_W'(acc * 10 + (b - CHAR_ZERO));
        end else bad = 1'b1;
        if (since_mark != 5'd31) since_mark++;
      end else if ((marks == MC_T_DOT || marks == MC_D_DOT) && since_mark < 2) begin
        if (is_dec) acc = ACC_W'(acc * 10 + (b - CHAR_ZERO));
        else bad = 1'b1;
        since_mark++;
        if (since_mark == 2 && !bad) begin
          if (marks == MC_T_DOT) begin
            temp_pend = minus ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
            temp_rdy = 1'b1;
          end else begin
            depth_pend = DEPTH_W'(minus ? -$signed({1'b0, acc}) : $signed({1'b0, acc}));
            depth_rdy = 1'b1;
          end
        end
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      res_t e;
      if (readings_q.size() == 0) begin
        $error("result with no line pending: tdata %h tuser %b", d, u);
        errors++;
        return;
      end
      e = readings_q.pop_front();
      if (d[17:0] !== e.temperature_centi) begin
        $error("temperature_centi: expected %0d, got %0d", e.temperature_centi,
               $signed(d[17:0]));
        errors++;
      end
      if (d[32:18] !== e.depth_centi) begin
        $error("depth_centi: expected %0d, got %0d", e.depth_centi, $signed(d[32:18]));
        errors++;
      end
      if (d[OUT_TDATA_W-1:33] !== '0) begin
        $error("tdata padding: expected 0, got %h", d[OUT_TDATA_W-1:33]);
        errors++;
      end
      if (u[0] !== e.temperature_updated) begin
        $error("temperature_updated: expected %b, got %b", e.temperature_updated, u[0]);
        errors++;
      end
      if (u[1] !== e.depth_updated) begin
        $error("depth_updated: expected %b, got %b", e.depth_updated, u[1]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  depth_line_scoreboard board;
  logic [7:0]           stim_q[$];
  int unsigned          bytes_in = 0;
  int unsigned          idle_cycles = 0;

  ascii_temp_depth_line_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] filler_char();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 126)); while (b == CHAR_EQ || b == CHAR_DOT);
    return b;
  endfunction

  function automatic logic [7:0] dec_char();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
    stim_q.push_back(CHAR_NL);
  endtask

  task automatic add_field();
    stim_q.push_back(($urandom_range(0, 9) == 0) ? CHAR_DOT : CHAR_EQ);
    case ($urandom_range(0, 15))
      0, 1, 2, 3: stim_q.push_back(dec_char());
      4, 5, 6, 7: repeat (2) stim_q.push_back(dec_char());
      8, 9, 10: begin
        stim_q.push_back(CHAR_MINUS);
        stim_q.push_back(dec_char());
      end
      11, 12: repeat (3) stim_q.push_back(dec_char());
      13: begin
        stim_q.push_back(CHAR_MINUS);
        repeat (2) stim_q.push_back(dec_char());
      end
      14: repeat ($urandom_range(0, 5)) stim_q.push_back(filler_char());
      default: repeat (4) stim_q.push_back(dec_char());
    endcase
    stim_q.push_back(($urandom_range(0, 9) == 0) ? CHAR_EQ : CHAR_DOT);
    case ($urandom_range(0, 9))
      7: stim_q.push_back(dec_char());
      8: begin
        stim_q.push_back(dec_char());
        stim_q.push_back(filler_char());
      end
      9: repeat (3) stim_q.push_back(dec_char());
      default: repeat (2) stim_q.push_back(dec_char());
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_byte(in_tdata);
      bytes_in <= bytes_in + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin : sink
    sink_mode_t  mode;
    int unsigned span;
    logic [7:0]  pat;
    bit          held_off;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      pat = 8'($urandom);
      // hold off long enough that a newline item backs up the input
      if (!held_off && bytes_in > 200) begin
        held_off = 1'b1;
        mode = SINK_HOLD;
        span = 400;
      end
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        case (mode)
          SINK_OPEN:    out_tready <= 1'b1;
          SINK_COIN:    out_tready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: out_tready <= pat[i % 8];
          SINK_SPARSE:  out_tready <= ($urandom_range(0, 3) == 0);
          default:      out_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned burst;
    board = new();
    stim_q.push_back(8'h00);
    stim_q.push_back(8'hFF);
    push_text("T=999.99D=-9.99");
    push_text("T=0.00");
    while (stim_q.size() < TARGET_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8)) stim_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) stim_q.push_back(filler_char());
        stim_q.push_back(CHAR_T);
        repeat ($urandom_range(0, 1)) stim_q.push_back(filler_char());
        add_field();
        if ($urandom_range(0, 5) != 0) begin
          repeat ($urandom_range(0, 3)) stim_q.push_back(filler_char());
          add_field();
        end
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2))
          stim_q.push_back(filler_char());
        if ($urandom_range(0, 3) == 0) stim_q.push_back(CHAR_EQ);
        if ($urandom_range(0, 11) != 0) stim_q.push_back(CHAR_NL);
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
      while (burst > 0 && stim_q.size() > 0) begin
        send_byte(stim_q.pop_front());
        burst--;
      end
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    while (board.readings_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
